>>> rtl/core/fpba_pkg.sv
// fpba_pkg: shared types and codes for the fit policy block allocator.
// Used by fpba_ctrl and fit_policy_block_allocator_unit.
package fpba_pkg;

  // Input operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // Fit policy codes (the unused code behaves as first fit)
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // Configuration register indexes and widths
  localparam int unsigned CFG_DATA_W = 5;
  localparam logic CFG_FIT_MODE    = 1'b0;
  localparam logic CFG_BLOCK_COUNT = 1'b1;

  localparam logic [1:0] FIT_MODE_RESET    = FIT_FIRST;
  localparam logic [4:0] BLOCK_COUNT_RESET = 5'd16;

  // Live configuration
  typedef struct packed {
    logic [1:0] fit_mode;
    logic [4:0] block_count;
  } cfg_t;

  // One allocation result
  typedef struct packed {
    logic        allocated;
    logic [3:0]  chosen_block;
    logic [15:0] remaining_after;
    logic        batch_end;
  } result_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_RESULT
  } state_t;

endpackage

>>> rtl/core/fpba_ram.sv
// fpba_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/fpba_ctrl.sv
// fpba_ctrl: request sequencer, table scan, fit selection and write-back.
// Depends on fpba_pkg; drives the ports of one fpba_ram instance.
module fpba_ctrl
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16,
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1,
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  input  logic                  op,
  input  logic [3:0]            load_index,
  input  logic [15:0]           request_size,
  input  logic                  last_in_batch,
  output logic                  busy,
  output logic                  ram_we,
  output logic [IDX_W-1:0]      ram_waddr,
  output logic [SIZE_WIDTH-1:0] ram_wdata,
  output logic                  ram_re,
  output logic [IDX_W-1:0]      ram_raddr,
  input  logic [SIZE_WIDTH-1:0] ram_rdata,
  output logic                  res_valid,
  output result_t               res,
  input  logic                  res_take
);

  state_t state, state_next;

  logic [MAX_BLOCKS-1:0] vld;
  logic [CNT_W-1:0]      issue_ptr;
  logic [CNT_W-1:0]      limit_q;
  logic                  chk_valid;
  logic [IDX_W-1:0]      chk_ptr;
  logic                  chk_vld;
  logic                  found;
  logic [IDX_W-1:0]      pick;
  logic [SIZE_WIDTH-1:0] best;
  logic [SIZE_WIDTH-1:0] req_q;
  logic                  last_q;

  // Input field resizing
  logic [SIZE_WIDTH+15:0] req_ext;
  logic [SIZE_WIDTH-1:0]  req_in;
  logic [IDX_W+3:0]       load_ext;
  logic [IDX_W-1:0]       load_addr;
  logic                   load_in_range;
  logic [CNT_W+4:0]       bc_ext;
  logic [CNT_W-1:0]       limit_in;

  assign req_ext       = {{SIZE_WIDTH{1'b0}}, request_size};
  assign req_in        = req_ext[SIZE_WIDTH-1:0];
  assign load_ext      = {{IDX_W{1'b0}}, load_index};
  assign load_addr     = load_ext[IDX_W-1:0];
  assign load_in_range = (32'(load_index) < MAX_BLOCKS);
  assign bc_ext        = {{CNT_W{1'b0}}, cfg.block_count};
  assign limit_in      = (32'(cfg.block_count) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                             : bc_ext[CNT_W-1:0];

  logic accept;
  assign accept = in_valid && (state == ST_IDLE);

  // Evaluation of the entry whose read data is back
  logic [SIZE_WIDTH-1:0] cur;
  logic                  fits;
  logic                  better;
  logic                  take;
  logic                  first_hit;
  logic                  last_chk;
  logic                  scan_done;
  logic                  issue_ok;

  assign cur       = chk_vld ? ram_rdata : '0;
  assign fits      = (cur >= req_q);
  assign better    = ((cfg.fit_mode == FIT_BEST) && (cur < best)) ||
                     ((cfg.fit_mode == FIT_WORST) && (cur > best));
  assign take      = chk_valid && fits && (!found || better);
  assign first_hit = chk_valid && fits && (cfg.fit_mode != FIT_BEST) &&
                     (cfg.fit_mode != FIT_WORST);
  assign last_chk  = ((CNT_W'(chk_ptr) + CNT_W'(1)) == limit_q);
  assign scan_done = chk_valid && (first_hit || last_chk);
  assign issue_ok  = (issue_ptr < limit_q) && !scan_done;

  // Remainder after the grant
  logic [SIZE_WIDTH-1:0]  new_val;
  logic [SIZE_WIDTH+15:0] new_ext;
  logic [IDX_W+3:0]       pick_ext;
  assign new_val  = best - req_q;
  assign new_ext  = {16'b0, new_val};
  assign pick_ext = {4'b0, pick};

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_ALLOC)) begin
          state_next = (limit_in == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE:  state_next = ST_RESULT;
      ST_RESULT: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs: stall, RAM ports, result
  always_comb begin
    busy      = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = pick;
    ram_wdata = new_val;
    ram_re    = 1'b0;
    ram_raddr = issue_ptr[IDX_W-1:0];
    res_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        busy      = 1'b0;
        ram_we    = accept && (op == OP_LOAD) && load_in_range;
        ram_waddr = load_addr;
        ram_wdata = req_in;
      end
      ST_SCAN:   ram_re = issue_ok;
      ST_WRITE:  ram_we = found;
      ST_RESULT: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.allocated       = found;
  assign res.chosen_block    = found ? pick_ext[3:0] : 4'd0;
  assign res.remaining_after = found ? new_ext[15:0] : 16'd0;
  assign res.batch_end       = last_q;

  // State and entry valid bits; an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      vld       <= '0;
      chk_valid <= 1'b0;
    end else begin
      state     <= state_next;
      chk_valid <= (state == ST_SCAN) && issue_ok;
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
    end
  end

  // Scan pointers and running choice
  always_ff @(posedge clk) begin
    if (accept && (op == OP_ALLOC)) begin
      issue_ptr <= '0;
      limit_q   <= limit_in;
      req_q     <= req_in;
      last_q    <= last_in_batch;
      found     <= 1'b0;
      pick      <= '0;
      best      <= '0;
    end else if (state == ST_SCAN) begin
      if (issue_ok) begin
        issue_ptr <= issue_ptr + CNT_W'(1);
      end
      if (take) begin
        found <= 1'b1;
        pick  <= chk_ptr;
        best  <= cur;
      end
    end
    chk_ptr <= issue_ptr[IDX_W-1:0];
    chk_vld <= vld[issue_ptr[IDX_W-1:0]];
  end

  // A granted entry always covers the request
  a_best_covers: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && found) |-> (best >= req_q))
    else $error("chosen entry smaller than request");

  // Write-back happens exactly when a block was granted
  a_write_on_grant: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (ram_we == found))
    else $error("write-back does not match grant");

  // Entries under check lie inside the scanned range
  a_chk_in_range: assert property (@(posedge clk) disable iff (rst)
    chk_valid |-> (CNT_W'(chk_ptr) < limit_q))
    else $error("scan checked an entry beyond the limit");

  // A delivered result frees the sequencer
  a_result_release: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && res_take) |=> (state == ST_IDLE))
    else $error("sequencer stuck after result");

endmodule

>>> rtl/core/fit_policy_block_allocator_unit.sv
// fit_policy_block_allocator_unit: top level; configuration registers, result register.
// Depends on fpba_pkg, fpba_ctrl and fpba_ram.
//
//  channel  signals                                          width   dir
//  in       in_valid/in_stall, op, load_index,               1/4/16/1 in
//           request_size, last_in_batch
//  out      out_valid/out_stall, allocated, chosen_block,    1/4/16/1 out
//           remaining_after, batch_end
//  cfg      cfg_write, cfg_index, cfg_data                   1/1/5   in
//
// A load request gives no result. An allocate request scans min(block_count,
// MAX_BLOCKS) table entries (fewer when first fit hits early, none when block_count
// is zero), with one table RAM read per cycle. Reset clears the table through
// per-entry valid bits, with no clearing pass. A stalled result sits in the
// output register while the next request is accepted.
module fit_policy_block_allocator_unit
  import fpba_pkg::*;
#(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  op,
  input  logic [3:0]            load_index,
  input  logic [15:0]           request_size,
  input  logic                  last_in_batch,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  allocated,
  output logic [3:0]            chosen_block,
  output logic [15:0]           remaining_after,
  output logic                  batch_end,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  cfg_t    cfg;
  logic    busy;
  logic    res_valid;
  logic    res_take;
  result_t res;
  result_t out_q;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [SIZE_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [SIZE_WIDTH-1:0] ram_rdata;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fit_mode    <= FIT_MODE_RESET;
      cfg.block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_FIT_MODE:    cfg.fit_mode    <= cfg_data[1:0];
        CFG_BLOCK_COUNT: cfg.block_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = busy;

  fpba_ctrl #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .op            (op),
    .load_index    (load_index),
    .request_size  (request_size),
    .last_in_batch (last_in_batch),
    .busy          (busy),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .res_valid     (res_valid),
    .res           (res),
    .res_take      (res_take)
  );

  fpba_ram #(
    .WIDTH (SIZE_WIDTH),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Output register: loads when empty or being drained
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign allocated       = out_q.allocated;
  assign chosen_block    = out_q.chosen_block;
  assign remaining_after = out_q.remaining_after;
  assign batch_end       = out_q.batch_end;

  // A result handed over is presented next cycle
  a_result_presented: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_take) |=> out_valid)
    else $error("result lost at output register");

  // No new request is taken while a result is pending in the sequencer
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_stall)
    else $error("request accepted while result pending");

  // Not-allocated results carry zero index and remainder
  a_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !allocated) |-> (chosen_block == 4'd0 && remaining_after == 16'd0))
    else $error("non-zero fields on a miss");

endmodule

>>> test/tb_top.sv
// tb_top: self-checking testbench for fit_policy_block_allocator_unit.
// Keeps its own copy of the free-space table to predict every grant.
// Depends on fpba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_top;
  import fpba_pkg::*;

  localparam int          TABLE_DEPTH     = 16;
  localparam int          PHASES          = 12;
  localparam int          REQS_PER_PHASE  = 150;
  localparam int          SETTLE_CYCLES   = 24;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam logic [1:0]  FIT_SPARE       = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  op = OP_LOAD;
  logic [3:0]            load_index = '0;
  logic [15:0]           request_size = '0;
  logic                  last_in_batch = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  allocated;
  logic [3:0]            chosen_block;
  logic [15:0]           remaining_after;
  logic                  batch_end;
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = CFG_FIT_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Mirror of the block's table and settings
  logic [15:0] free_tbl [TABLE_DEPTH];
  logic [1:0]  mode_q;
  logic [4:0]  count_q;
  result_t     grant_q[$];

  int fail_count     = 0;
  int requests_seen  = 0;
  int allocs_seen    = 0;
  int grants_seen    = 0;
  int settings_seen  = 0;
  int quiet_cycles   = 0;
  bit no_idle        = 1'b0;

  fit_policy_block_allocator_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .op              (op),
    .load_index      (load_index),
    .request_size    (request_size),
    .last_in_batch   (last_in_batch),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .allocated       (allocated),
    .chosen_block    (chosen_block),
    .remaining_after (remaining_after),
    .batch_end       (batch_end),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pick a block for one allocate request and shrink it; mirrors the scan order
  function automatic result_t allocate_from_table(logic [15:0] sz, logic last);
    result_t r;
    int      span;
    int      pick;
    bit      hit;
    bit      done;
    r    = '0;
    pick = 0;
    hit  = 1'b0;
    done = 1'b0;
    span = (count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_q);
    for (int j = 0; j < span; j++) begin
      if (!done && free_tbl[j] >= sz) begin
        if (!hit) begin
          hit  = 1'b1;
          pick = j;
          // anything but best or worst stops at the first fit
          done = (mode_q != FIT_BEST && mode_q != FIT_WORST);
        end else if (mode_q == FIT_BEST && free_tbl[j] < free_tbl[pick]) begin
          pick = j;
        end else if (mode_q == FIT_WORST && free_tbl[j] > free_tbl[pick]) begin
          pick = j;
        end
      end
    end
    if (hit) begin
      free_tbl[pick]    = free_tbl[pick] - sz;
      r.allocated       = 1'b1;
      r.chosen_block    = 4'(pick);
      r.remaining_after = free_tbl[pick];
    end
    r.batch_end = last;
    return r;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : int'($urandom_range(0, 16));
  endfunction

  // Sizes skewed towards values that fit, with some full-range and zero draws
  function automatic logic [15:0] draw_size(bit for_alloc);
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'h0000;
      2:       return for_alloc ? 16'($urandom_range(0, 300)) : 16'hFFFF;
      3:       return 16'($urandom_range(0, 4095));
      default: return for_alloc ? free_tbl[$urandom_range(0, TABLE_DEPTH - 1)]
                                : 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Predict on accepted requests, check accepted results, watch for a hang
  always @(posedge clk) begin : track
    result_t want;
    bit      moved;
    moved = 1'b0;
    if (rst) begin
      foreach (free_tbl[k]) free_tbl[k] = '0;
      mode_q  = FIT_MODE_RESET;
      count_q = BLOCK_COUNT_RESET;
      grant_q.delete();
    end else begin
      if (cfg_write) begin
        moved = 1'b1;
        case (cfg_index)
          CFG_FIT_MODE:    mode_q  = cfg_data[1:0];
          CFG_BLOCK_COUNT: count_q = cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        requests_seen++;
        if (op == OP_LOAD) begin
          free_tbl[load_index] = request_size;
        end else begin
          allocs_seen++;
          grant_q.push_back(allocate_from_table(request_size, last_in_batch));
        end
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (grant_q.size() == 0) begin
          $error("result with no allocate request pending");
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (want.allocated) grants_seen++;
          check_field("allocated", want.allocated, allocated);
          check_field("chosen_block", want.chosen_block, chosen_block);
          check_field("remaining_after", want.remaining_after, remaining_after);
          check_field("batch_end", want.batch_end, batch_end);
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stall before taking each result
  initial begin : result_sink
    int gap;
    forever begin
      @(negedge clk);
      gap = draw_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offer one request after a random gap and hold it until taken
  task automatic send_request(input logic o, input logic [3:0] idx,
                              input logic [15:0] sz, input logic last);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid      <= 1'b0;
      op            <= 1'($urandom_range(0, 1));
      load_index    <= 4'($urandom_range(0, 15));
      request_size  <= 16'($urandom_range(0, 65535));
      last_in_batch <= 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    op            <= o;
    load_index    <= idx;
    request_size  <= sz;
    last_in_batch <= last;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid, let all grants arrive, then allow for a trailing scan
  task automatic wait_until_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_fit(input logic [1:0] mode);
    wait_until_idle();
    write_reg(CFG_FIT_MODE, CFG_DATA_W'(mode));
    settings_seen++;
  endtask

  task automatic set_count(input logic [4:0] cnt);
    wait_until_idle();
    write_reg(CFG_BLOCK_COUNT, cnt);
    settings_seen++;
  endtask

  // Table is empty after reset: a zero request fits, anything larger does not
  task automatic test_reset_table();
    send_request(OP_ALLOC, 4'd0, 16'd0, 1'b1);
    send_request(OP_ALLOC, 4'd9, 16'd1, 1'b0);
  endtask

  task automatic test_first_fit();
    set_fit(FIT_FIRST);
    send_request(OP_LOAD, 4'd0, 16'd5, 1'b0);
    send_request(OP_LOAD, 4'd3, 16'hFFFF, 1'b1);
    send_request(OP_LOAD, 4'd7, 16'd7, 1'b0);
    send_request(OP_LOAD, 4'd15, 16'd7, 1'b1);
    send_request(OP_ALLOC, 4'd0, 16'd6, 1'b1);
  endtask

  // Equal remainders at 7 and 15: the lower index wins
  task automatic test_best_fit();
    set_fit(FIT_BEST);
    send_request(OP_ALLOC, 4'd0, 16'd6, 1'b0);
    send_request(OP_ALLOC, 4'd0, 16'd0, 1'b1);
  endtask

  task automatic test_worst_fit();
    set_fit(FIT_WORST);
    send_request(OP_LOAD, 4'd8, 16'hFFF9, 1'b0);
    send_request(OP_ALLOC, 4'd0, 16'h8000, 1'b0);
    send_request(OP_ALLOC, 4'd0, 16'hFFFF, 1'b1);
  endtask

  // Unused mode code falls back to first fit
  task automatic test_spare_mode();
    set_fit(FIT_SPARE);
    send_request(OP_ALLOC, 4'd0, 16'd5, 1'b1);
  endtask

  // Empty scan, single entry, full table and saturating counts
  task automatic test_scan_limits();
    set_count(5'd0);
    send_request(OP_ALLOC, 4'd0, 16'd0, 1'b1);
    set_count(5'd1);
    send_request(OP_ALLOC, 4'd0, 16'd0, 1'b0);
    set_count(5'd31);
    send_request(OP_ALLOC, 4'd0, 16'd7, 1'b1);
    set_count(5'd17);
    send_request(OP_ALLOC, 4'd0, 16'd1, 1'b0);
    set_count(5'd16);
  endtask

  // Phases of mixed loads and allocations, each under a fresh random setting
  task automatic test_random_traffic();
    logic [4:0] cnt;
    for (int p = 0; p < PHASES; p++) begin
      no_idle = (p % 3 == 2);
      wait_until_idle();
      write_reg(CFG_FIT_MODE, CFG_DATA_W'($urandom_range(0, 31)));
      cnt = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                        : 5'($urandom_range(1, 16));
      write_reg(CFG_BLOCK_COUNT, cnt);
      settings_seen++;
      for (int n = 0; n < REQS_PER_PHASE; n++) begin
        if ($urandom_range(0, 9) < 3)
          send_request(OP_LOAD, 4'($urandom_range(0, 15)), draw_size(1'b0),
                       1'($urandom_range(0, 1)));
        else
          send_request(OP_ALLOC, 4'($urandom_range(0, 15)), draw_size(1'b1),
                       1'($urandom_range(0, 1)));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_table();
    test_first_fit();
    test_best_fit();
    test_worst_fit();
    test_spare_mode();
    test_scan_limits();
    test_random_traffic();
    wait_until_idle();

    $display("Sent %0d requests: %0d allocations checked, %0d granted,",
             requests_seen, allocs_seen, grants_seen);
    $display("under %0d register settings across all fit modes and block counts",
             settings_seen);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
